[rtl/byte_stuffing_framer_unit_assert.svh]
// Assertion macros for the byte stuffing framer.
// Included by the port checker; no other dependencies.
`ifndef BYTE_STUFFING_FRAMER_UNIT_ASSERT_SVH
`define BYTE_STUFFING_FRAMER_UNIT_ASSERT_SVH

// Implication checked at every edge outside reset.
`define BSF_ASSERT_IMPL(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("bsf check failed");

// Next-cycle implication checked outside reset.
`define BSF_ASSERT_NEXT(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("bsf check failed");

// Implication checked at every edge, reset included.
`define BSF_ASSERT_ALWAYS(lbl, clk, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |-> (con)) \
    else $error("bsf check failed");

`endif

[rtl/bsf_pkg.sv]
// Shared types and constants for the byte stuffing framer.
// No dependencies.
`default_nettype none
package bsf_pkg;

  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int JOB_MAX  = 4;
  localparam int JOB_CNT_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_FLAG      = 2'd1,
    CFG_ESCAPE    = 2'd2
  } bsf_cfg_idx_t;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;

  // One classified input beat: up to four output bytes
  typedef struct packed {
    logic [JOB_CNT_W-1:0]           cnt;
    logic [JOB_MAX-1:0][BYTE_W-1:0] data;
    logic                           last;
  } bsf_job_t;

endpackage
`default_nettype wire

[rtl/bsf_if.sv]
// Handshake interfaces for the byte stuffing framer channels.
// Depends on bsf_pkg.
`default_nettype none
interface bsf_in_if import bsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface bsf_out_if import bsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface bsf_cfg_if import bsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/bsf_fifo.sv]
// Short job queue between the classifier and the byte sender.
// Depends on bsf_pkg.
`default_nettype none
module bsf_fifo import bsf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire bsf_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output bsf_job_t      head,
  output logic          head_valid
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bsf_job_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/bsf_front.sv]
// Front end: config registers, input acceptance and frame classification.
// Turns each input beat into a job of up to four bytes. Depends on bsf_pkg.
`default_nettype none
module bsf_front import bsf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bsf_in_if.sink     in_stream,
  bsf_cfg_if.sink    cfg,
  input  wire logic  queue_full,
  output logic       push,
  output bsf_job_t   push_job
);
  // Configuration
  logic              direction;
  logic [BYTE_W-1:0] flag_value;
  logic [BYTE_W-1:0] escape_value;

  // Frame state
  logic              mid_frame;
  logic              escape_pending;
  logic [BYTE_W-1:0] held_byte;
  logic              held_valid;

  logic              mid_frame_next;
  logic              escape_pending_next;
  logic [BYTE_W-1:0] held_byte_next;
  logic              held_valid_next;

  logic              accept;
  logic              cfg_wr;
  logic              dir_wr;
  bsf_job_t          job;

  assign cfg.ready       = 1'b1;
  assign in_stream.ready = !queue_full;
  assign accept          = in_stream.valid && !queue_full;
  assign cfg_wr          = cfg.valid;
  assign dir_wr          = cfg_wr && (cfg.index == CFG_DIRECTION);
  assign push            = accept && (job.cnt != '0);
  assign push_job        = job;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_ENCODE;
      flag_value   <= FLAG_RESET;
      escape_value <= ESCAPE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        CFG_DIRECTION: direction    <= cfg.data[0];
        CFG_FLAG:      flag_value   <= cfg.data;
        CFG_ESCAPE:    escape_value <= cfg.data;
        default:       ;
      endcase
    end
  end

  // Classify one beat into a job and the next frame state
  always_comb begin
    logic b_special;
    b_special           = (in_stream.in_byte == flag_value) ||
                          (in_stream.in_byte == escape_value);
    job                 = '0;
    mid_frame_next      = mid_frame;
    escape_pending_next = escape_pending;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;

    if (direction == DIR_ENCODE) begin
      if (!mid_frame) begin
        job.data[job.cnt[1:0]] = flag_value;
        job.cnt                = job.cnt + 1'b1;
        mid_frame_next         = 1'b1;
      end
      if (b_special) begin
        job.data[job.cnt[1:0]] = escape_value;
        job.cnt                = job.cnt + 1'b1;
      end
      job.data[job.cnt[1:0]] = in_stream.in_byte;
      job.cnt                = job.cnt + 1'b1;
      if (in_stream.in_last) begin
        job.data[job.cnt[1:0]] = flag_value;
        job.cnt                = job.cnt + 1'b1;
        job.last               = 1'b1;
        mid_frame_next         = 1'b0;
        escape_pending_next    = 1'b0;
        held_byte_next         = '0;
        held_valid_next        = 1'b0;
      end
    end else begin
      if (!mid_frame) begin
        // opening byte dropped
        mid_frame_next = !in_stream.in_last;
      end else if (in_stream.in_last) begin
        // closing byte dropped; flush the hold stage
        if (escape_pending) begin
          if (held_valid_next) begin
            job.data[job.cnt[1:0]] = held_byte_next;
            job.cnt                = job.cnt + 1'b1;
          end
          held_byte_next  = escape_value;
          held_valid_next = 1'b1;
        end
        if (held_valid_next) begin
          job.data[job.cnt[1:0]] = held_byte_next;
          job.cnt                = job.cnt + 1'b1;
          job.last               = 1'b1;
        end
        mid_frame_next      = 1'b0;
        escape_pending_next = 1'b0;
        held_byte_next      = '0;
        held_valid_next     = 1'b0;
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (!b_special) begin
          if (held_valid_next) begin
            job.data[job.cnt[1:0]] = held_byte_next;
            job.cnt                = job.cnt + 1'b1;
          end
          held_byte_next  = escape_value;
          held_valid_next = 1'b1;
        end
        if (held_valid_next) begin
          job.data[job.cnt[1:0]] = held_byte_next;
          job.cnt                = job.cnt + 1'b1;
        end
        held_byte_next  = in_stream.in_byte;
        held_valid_next = 1'b1;
      end else if (in_stream.in_byte == escape_value) begin
        escape_pending_next = 1'b1;
      end else begin
        if (held_valid_next) begin
          job.data[job.cnt[1:0]] = held_byte_next;
          job.cnt                = job.cnt + 1'b1;
        end
        held_byte_next  = in_stream.in_byte;
        held_valid_next = 1'b1;
      end
    end
  end

  // Frame state update; a direction write aborts the frame
  always_ff @(posedge clk) begin
    if (rst || dir_wr) begin
      mid_frame      <= 1'b0;
      escape_pending <= 1'b0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
    end else if (accept) begin
      mid_frame      <= mid_frame_next;
      escape_pending <= escape_pending_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
    end
  end
endmodule
`default_nettype wire

[rtl/bsf_back.sv]
// Back end: walks the head job one byte per beat into the output register.
// Depends on bsf_pkg.
`default_nettype none
module bsf_back import bsf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire bsf_job_t head,
  input  wire logic     head_valid,
  output logic          pop,
  bsf_out_if.source     out_stream
);
  logic [1:0]        pos;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              load;
  logic              at_end;

  assign load   = head_valid && (!out_valid || out_stream.ready);
  assign at_end = ({1'b0, pos} == JOB_CNT_W'(head.cnt - 1'b1));
  assign pop    = load && at_end;

  assign out_stream.valid    = out_valid;
  assign out_stream.out_byte = out_byte;
  assign out_stream.out_last = out_last;

  // Byte position within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= at_end ? '0 : pos + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.data[pos];
      out_last <= head.last && at_end;
    end
  end
endmodule
`default_nettype wire

[rtl/byte_stuffing_framer_unit.sv]
// Flag/escape byte stuffing framer and deframer, direction set by register.
// Path: each input beat is classified combinationally, queued as a job, then
// walked byte by byte into the output register. Input takes one beat per cycle
// while the queue is not full; output sends one byte per cycle while ready.
// Reset: synchronous; clears frame state, queue and output, restores registers.
`default_nettype none
module byte_stuffing_framer_unit import bsf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  bsf_in_if.sink    in_stream,
  bsf_out_if.source out_stream,
  bsf_cfg_if.sink   cfg
);
  logic     push;
  bsf_job_t push_job;
  logic     full;
  logic     pop;
  bsf_job_t head;
  logic     head_valid;

  bsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .cfg        (cfg),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  bsf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  bsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_stream (out_stream)
  );
endmodule
`default_nettype wire

[rtl/bsf_checker.sv]
// Port-level checks for the byte stuffing framer, bound to the top level.
// Depends on bsf_pkg and the assertion macro header.
`default_nettype none
`include "byte_stuffing_framer_unit_assert.svh"
module bsf_checker import bsf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              out_last,
  input wire logic              cfg_ready
);
  // stalled output beat holds
  `BSF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))
  // no output beat right after reset
  `BSF_ASSERT_ALWAYS(a_out_reset, clk, $past(rst), !out_valid)
  // queue is empty after reset, so input is taken
  `BSF_ASSERT_ALWAYS(a_in_reset, clk, $past(rst), in_ready)
  // config writes are never stalled
  `BSF_ASSERT_IMPL(a_cfg_ready, clk, rst, 1'b1, cfg_ready)
endmodule

bind byte_stuffing_framer_unit bsf_checker u_bsf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_byte  (out_stream.out_byte),
  .out_last  (out_stream.out_last),
  .cfg_ready (cfg.ready)
);
`default_nettype wire

[tb/sv/byte_stuffing_framer_unit_test.sv]
// Self-checking testbench for the byte stuffing framer/deframer unit.
// Depends on bsf_pkg, the bsf_if interfaces and byte_stuffing_framer_unit.
// Predicts every output beat in both directions and checks it in order.
`default_nettype none
module byte_stuffing_framer_unit_test;
  import bsf_pkg::*;

  localparam int RANDOM_BEATS = 420;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 600000;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } framed_beat_t;

  logic clk = 1'b0;
  logic rst;

  bsf_in_if  in_ch ();
  bsf_out_if out_ch ();
  bsf_cfg_if cfg_ch ();

  byte_stuffing_framer_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg        (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted register and frame state
  logic              cur_direction;
  logic [BYTE_W-1:0] cur_flag;
  logic [BYTE_W-1:0] cur_escape;
  logic              in_frame;
  logic              esc_seen;
  logic [BYTE_W-1:0] hold_byte;
  logic              hold_full;

  framed_beat_t due_bytes[$];

  int err_count     = 0;
  int beats_sent    = 0;
  int rand_beats    = 0;
  int bytes_checked = 0;
  int cfg_writes    = 0;
  int cycle_count   = 0;
  bit quiet_mode    = 1'b0;
  int stall_left    = 0;

  function automatic void push_due(input logic [BYTE_W-1:0] b, input logic last);
    framed_beat_t fb;
    fb.data = b;
    fb.last = last;
    due_bytes = {due_bytes, fb};
  endfunction

  function automatic void clear_frame_state();
    in_frame  = 1'b0;
    esc_seen  = 1'b0;
    hold_byte = '0;
    hold_full = 1'b0;
  endfunction

  // Decoder output goes through a one-byte hold so the final byte can carry last
  function automatic void pass_through_hold(input logic [BYTE_W-1:0] b);
    if (hold_full) push_due(hold_byte, 1'b0);
    hold_byte = b;
    hold_full = 1'b1;
  endfunction

  function automatic bit is_special(input logic [BYTE_W-1:0] b);
    return (b == cur_flag) || (b == cur_escape);
  endfunction

  // Expected output bytes for one accepted input beat
  function automatic void codec_predict(input logic [BYTE_W-1:0] b, input logic last);
    if (cur_direction == DIR_ENCODE) begin
      if (!in_frame) begin
        push_due(cur_flag, 1'b0);
        in_frame = 1'b1;
      end
      if (is_special(b)) push_due(cur_escape, 1'b0);
      push_due(b, 1'b0);
      if (last) begin
        push_due(cur_flag, 1'b1);
        clear_frame_state();
      end
    end else if (!in_frame) begin
      // opening byte is dropped by position
      if (!last) in_frame = 1'b1;
    end else if (last) begin
      // closing byte dropped; a dangling escape is kept as data
      if (esc_seen) pass_through_hold(cur_escape);
      if (hold_full) push_due(hold_byte, 1'b1);
      clear_frame_state();
    end else if (esc_seen) begin
      esc_seen = 1'b0;
      if (!is_special(b)) pass_through_hold(cur_escape);
      pass_through_hold(b);
    end else if (b == cur_escape) begin
      esc_seen = 1'b1;
    end else begin
      pass_through_hold(b);
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Byte biased toward the current flag and escape values
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return cur_flag;
    if (r < 40) return cur_escape;
    if (r < 45) return 8'h00;
    if (r < 50) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Send one input beat; valid stays high when the next beat follows at once
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    in_ch.valid   <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    codec_predict(b, last);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop input valid, wait for all predicted bytes, then let the pipe settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    wait_idle();
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_DIRECTION: begin
        cur_direction = val[0];
        clear_frame_state();
      end
      CFG_FLAG:   cur_flag = val;
      CFG_ESCAPE: cur_escape = val;
      default: ;
    endcase
  endtask

  // Encoder with reset register values: specials inside a frame, one-byte frame
  task automatic test_reset_defaults();
    send_beat(8'd126, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'd125, 1'b0);
    send_beat(8'd126, 1'b1);
  endtask

  // Encoder with extreme register values and with flag equal to escape
  task automatic test_encode_extremes();
    cfg_write(CFG_FLAG, 8'h00);
    cfg_write(CFG_ESCAPE, 8'hFF);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h55, 1'b1);
    cfg_write(CFG_FLAG, 8'h42);
    cfg_write(CFG_ESCAPE, 8'h42);
    send_beat(8'h42, 1'b0);
    send_beat(8'h41, 1'b1);
  endtask

  // Decoder corner cases
  task automatic test_decode_cases();
    cfg_write(CFG_DIRECTION, BYTE_W'(DIR_DECODE));
    cfg_write(CFG_FLAG, 8'h7E);
    cfg_write(CFG_ESCAPE, 8'h7D);
    // one-byte and two-byte frames give nothing
    send_beat(8'h7E, 1'b1);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h7E, 1'b1);
    // escape right before the closing byte is data
    send_beat(8'h7E, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h7E, 1'b1);
    // escaped escape, then an escape before an ordinary byte
    send_beat(8'h7E, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h7E, 1'b1);
    // flag equal to escape: escape before the shared value is dropped
    cfg_write(CFG_FLAG, 8'h42);
    cfg_write(CFG_ESCAPE, 8'h42);
    send_beat(8'h00, 1'b0);
    send_beat(8'h42, 1'b0);
    send_beat(8'h42, 1'b0);
    send_beat(8'h13, 1'b1);
  endtask

  // Direction write aborts a frame; flag write applies mid-frame; bad index ignored
  task automatic test_abort_and_update();
    cfg_write(CFG_FLAG, 8'h7E);
    cfg_write(CFG_ESCAPE, 8'h7D);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h43, 1'b0);
    cfg_write(CFG_DIRECTION, BYTE_W'(DIR_ENCODE));
    send_beat(8'h10, 1'b0);
    cfg_write(CFG_FLAG, 8'h10);
    send_beat(8'h10, 1'b1);
    cfg_write(CFG_UNUSED, 8'hA5);
    send_beat(8'hA5, 1'b1);
  endtask

  // Random settings, then a run of frames; decoder mostly sees well-formed frames
  task automatic test_random_frames();
    int unsigned r;
    int n_frames;
    int len;
    logic [BYTE_W-1:0] b;
    while (rand_beats < RANDOM_BEATS) begin
      cfg_write(CFG_DIRECTION, BYTE_W'($urandom_range(0, 1)));
      r = $urandom_range(0, 9);
      if (r < 2) cfg_write(CFG_FLAG, r == 0 ? 8'h00 : 8'hFF);
      else if (r < 7) cfg_write(CFG_FLAG, BYTE_W'($urandom_range(0, 255)));
      r = $urandom_range(0, 9);
      if (r == 0) cfg_write(CFG_ESCAPE, cur_flag);
      else if (r < 3) cfg_write(CFG_ESCAPE, r == 1 ? 8'h00 : 8'hFF);
      else if (r < 8) cfg_write(CFG_ESCAPE, BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) cfg_write(CFG_UNUSED, BYTE_W'($urandom_range(0, 255)));
      quiet_mode = ($urandom_range(0, 3) == 0);
      n_frames = $urandom_range(3, 8);
      repeat (n_frames) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        if (cur_direction == DIR_ENCODE) begin
          for (int k = 0; k < len; k++) begin
            send_beat(pick_byte(), k == len - 1);
            rand_beats++;
          end
        end else if ($urandom_range(0, 4) != 0) begin
          // well-formed stuffed frame around random content
          send_beat(cur_flag, 1'b0);
          rand_beats++;
          for (int k = 0; k < len - 1; k++) begin
            b = pick_byte();
            if (is_special(b)) begin
              send_beat(cur_escape, 1'b0);
              rand_beats++;
            end
            send_beat(b, 1'b0);
            rand_beats++;
          end
          send_beat(cur_flag, 1'b1);
          rand_beats++;
        end else begin
          // noise: arbitrary bytes, stray escapes included
          for (int k = 0; k < len; k++) begin
            send_beat(pick_byte(), k == len - 1);
            rand_beats++;
          end
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  // Output side: random backpressure, short stalls mostly, a few long ones
  always @(posedge clk) begin : drive_out_ready
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (quiet_mode || r < 65) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 30);
    end
  end

  // Compare every accepted output beat with the oldest prediction
  always @(posedge clk) begin : check_out
    framed_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_bytes.size() == 0) begin
        $error("unexpected output beat: out_byte=%02h out_last=%0b",
               out_ch.out_byte, out_ch.out_last);
        err_count++;
      end else begin
        want = due_bytes.pop_front();
        bytes_checked++;
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want.data, out_ch.out_byte);
          err_count++;
        end
        if (out_ch.out_last !== want.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", want.last, out_ch.out_last);
          err_count++;
        end
      end
    end
  end

  // Watchdog on total run length
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d bytes still due", cycle_count, due_bytes.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    in_ch.in_last  = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_DIRECTION;
    cfg_ch.data    = '0;
    cur_direction  = DIR_ENCODE;
    cur_flag       = FLAG_RESET;
    cur_escape     = ESCAPE_RESET;
    clear_frame_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_encode_extremes();
    test_decode_cases();
    test_abort_and_update();
    test_random_frames();

    wait_idle();
    if (due_bytes.size() != 0) begin
      $error("%0d predicted output bytes never arrived", due_bytes.size());
      err_count++;
    end
    $display("covered %0d input beats (%0d random) and %0d output bytes in both directions,",
             beats_sent, rand_beats, bytes_checked);
    $display("with %0d register writes across flag/escape settings and frame aborts",
             cfg_writes);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
